FILE: rtl/gref_pkg.sv
// shared action and status codes for the grant reference free-list allocator
`default_nettype none

package gref_pkg;

    localparam logic [2:0] ACT_ALLOC      = 3'd0;
    localparam logic [2:0] ACT_FREE_ONE   = 3'd1;
    localparam logic [2:0] ACT_FREE_CHAIN = 3'd2;
    localparam logic [2:0] ACT_CLAIM      = 3'd3;
    localparam logic [2:0] ACT_RELEASE    = 3'd4;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/gref_ram.sv
// generic single write port, single read port ram with registered read data
`default_nettype none

module gref_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/grant_ref_free_list_allocator_core.sv
// top level: free list of grant references kept as next-links in a ram
//
// input channel: in_valid / in_stall with action, count, entry_ref and
// caller_head; one word is taken only while the sequencer is idle.
// output channel: out_valid / out_stall with status, result_ref,
// new_caller_head and free_left; exactly one output word per input word.
// each word passes through the exec and done states; alloc and free chain
// also walk the links in the walk or chain state (alloc counts 0 as 1 and
// stops early on a short list), and claim reads its link in the claim state.
// no new word is taken until the previous one has left the done state; the
// link walks run at one ram read per cycle through the single read port.
// after reset a clearing pass writes the initial links, one entry per
// cycle; in_stall stays high during the pass.
// a finished word sits in the output register while out_stall is high,
// and the next item may be accepted meanwhile but waits to retire.
`default_nettype none

module grant_ref_free_list_allocator_core #(
    parameter int ENTRIES  = 256,
    parameter int RESERVED = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [2:0]                      action,
    input  wire logic [$clog2(ENTRIES+2)-1:0]    count,
    input  wire logic [$clog2(ENTRIES+2)-1:0]    entry_ref,
    input  wire logic [$clog2(ENTRIES+2)-1:0]    caller_head,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 status,
    output logic      [$clog2(ENTRIES+2)-1:0]    result_ref,
    output logic      [$clog2(ENTRIES+2)-1:0]    new_caller_head,
    output logic      [$clog2(ENTRIES+2)-1:0]    free_left
);

    localparam int REF_W = $clog2(ENTRIES + 2);
    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [REF_W-1:0] END_MARK  = REF_W'(ENTRIES + 1);
    localparam logic [REF_W-1:0] ENT_REF   = REF_W'(ENTRIES);
    localparam logic [REF_W-1:0] RESV_REF  = REF_W'(RESERVED);
    localparam logic [REF_W-1:0] FREE_INIT = REF_W'(ENTRIES - RESERVED);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_CHAIN,
        ST_CLAIM,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  init_cnt_reg, init_cnt_next;
    logic [2:0]        act_reg, act_next;
    logic [REF_W-1:0]  cnt_reg, cnt_next;
    logic [REF_W-1:0]  eref_reg, eref_next;
    logic [REF_W-1:0]  phead_reg, phead_next;
    logic [REF_W-1:0]  free_head_reg, free_head_next;
    logic [REF_W-1:0]  free_total_reg, free_total_next;
    logic [REF_W-1:0]  cur_reg, cur_next;
    logic [REF_W-1:0]  k_reg, k_next;
    logic              res_status_reg, res_status_next;
    logic [REF_W-1:0]  res_ref_reg, res_ref_next;
    logic [REF_W-1:0]  res_newp_reg, res_newp_next;
    logic              out_valid_reg, out_valid_next;
    logic              status_reg, status_next;
    logic [REF_W-1:0]  result_ref_reg, result_ref_next;
    logic [REF_W-1:0]  new_caller_head_reg, new_caller_head_next;
    logic [REF_W-1:0]  free_left_reg, free_left_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [REF_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [REF_W-1:0]  ram_rdata;
    logic [REF_W-1:0]  init_val;
    logic [REF_W-1:0]  nx;

    function automatic logic [REF_W-1:0] sat_add(input logic [REF_W-1:0] a,
                                                 input logic [REF_W-1:0] b);
        logic [REF_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum > {1'b0, ENT_REF})
        begin
            return ENT_REF;
        end
        return sum[REF_W-1:0];
    endfunction

    gref_ram #(
        .WIDTH (REF_W),
        .DEPTH (ENTRIES)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign nx = ram_rdata;
    assign init_val = (REF_W'(init_cnt_reg) >= RESV_REF && init_cnt_reg != LAST_IDX)
                      ? REF_W'(init_cnt_reg) + REF_W'(1) : END_MARK;

    always_comb
    begin
        state_next            = state_reg;
        init_cnt_next         = init_cnt_reg;
        act_next              = act_reg;
        cnt_next              = cnt_reg;
        eref_next             = eref_reg;
        phead_next            = phead_reg;
        free_head_next        = free_head_reg;
        free_total_next       = free_total_reg;
        cur_next              = cur_reg;
        k_next                = k_reg;
        res_status_next       = res_status_reg;
        res_ref_next          = res_ref_reg;
        res_newp_next         = res_newp_reg;
        out_valid_next        = out_valid_reg;
        status_next           = status_reg;
        result_ref_next       = result_ref_reg;
        new_caller_head_next  = new_caller_head_reg;
        free_left_next        = free_left_reg;
        ram_we                = 1'b0;
        ram_waddr             = '0;
        ram_wdata             = '0;
        ram_re                = 1'b0;
        ram_raddr             = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = init_cnt_reg;
                ram_wdata = init_val;
                if (init_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    init_cnt_next = init_cnt_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action;
                    cnt_next   = (count == '0) ? REF_W'(1) : count;
                    eref_next  = entry_ref;
                    phead_next = caller_head;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_status_next = gref_pkg::STATUS_OK;
                res_ref_next    = END_MARK;
                res_newp_next   = phead_reg;
                state_next      = ST_DONE;
                unique case (act_reg)
                    gref_pkg::ACT_ALLOC:
                    begin
                        if (free_total_reg < cnt_reg || free_head_reg >= ENT_REF)
                        begin
                            res_status_next = gref_pkg::STATUS_NO_SPACE;
                        end
                        else
                        begin
                            res_ref_next    = free_head_reg;
                            free_total_next = free_total_reg - cnt_reg;
                            cur_next        = free_head_reg;
                            k_next          = REF_W'(1);
                            ram_re          = 1'b1;
                            ram_raddr       = free_head_reg[IDX_W-1:0];
                            state_next      = ST_WALK;
                        end
                    end
                    gref_pkg::ACT_FREE_ONE:
                    begin
                        if (eref_reg < ENT_REF)
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = eref_reg[IDX_W-1:0];
                            ram_wdata       = free_head_reg;
                            free_head_next  = eref_reg;
                            free_total_next = sat_add(free_total_reg, REF_W'(1));
                        end
                    end
                    gref_pkg::ACT_FREE_CHAIN:
                    begin
                        if (eref_reg < ENT_REF)
                        begin
                            cur_next   = eref_reg;
                            k_next     = REF_W'(1);
                            ram_re     = 1'b1;
                            ram_raddr  = eref_reg[IDX_W-1:0];
                            state_next = ST_CHAIN;
                        end
                    end
                    gref_pkg::ACT_CLAIM:
                    begin
                        if (phead_reg >= ENT_REF)
                        begin
                            res_status_next = gref_pkg::STATUS_NO_SPACE;
                        end
                        else
                        begin
                            res_ref_next = phead_reg;
                            ram_re       = 1'b1;
                            ram_raddr    = phead_reg[IDX_W-1:0];
                            state_next   = ST_CLAIM;
                        end
                    end
                    gref_pkg::ACT_RELEASE:
                    begin
                        if (eref_reg < ENT_REF)
                        begin
                            ram_we        = 1'b1;
                            ram_waddr     = eref_reg[IDX_W-1:0];
                            ram_wdata     = phead_reg;
                            res_newp_next = eref_reg;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_WALK:
            begin
                if (k_reg < cnt_reg && nx < ENT_REF)
                begin
                    cur_next  = nx;
                    k_next    = k_reg + REF_W'(1);
                    ram_re    = 1'b1;
                    ram_raddr = nx[IDX_W-1:0];
                end
                else
                begin
                    free_head_next = nx;
                    ram_we         = 1'b1;
                    ram_waddr      = cur_reg[IDX_W-1:0];
                    ram_wdata      = END_MARK;
                    state_next     = ST_DONE;
                end
            end
            ST_CHAIN:
            begin
                if (k_reg <= ENT_REF && nx < ENT_REF)
                begin
                    cur_next  = nx;
                    k_next    = k_reg + REF_W'(1);
                    ram_re    = 1'b1;
                    ram_raddr = nx[IDX_W-1:0];
                end
                else
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = cur_reg[IDX_W-1:0];
                    ram_wdata       = free_head_reg;
                    free_head_next  = eref_reg;
                    free_total_next = sat_add(free_total_reg, k_reg);
                    state_next      = ST_DONE;
                end
            end
            ST_CLAIM:
            begin
                res_newp_next = nx;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next        = 1'b1;
                    status_next           = res_status_reg;
                    result_ref_next       = res_ref_reg;
                    new_caller_head_next  = res_newp_reg;
                    free_left_next        = free_total_reg;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            init_cnt_reg   <= '0;
            free_head_reg  <= RESV_REF;
            free_total_reg <= FREE_INIT;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            init_cnt_reg   <= init_cnt_next;
            free_head_reg  <= free_head_next;
            free_total_reg <= free_total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg              <= act_next;
        cnt_reg              <= cnt_next;
        eref_reg             <= eref_next;
        phead_reg            <= phead_next;
        cur_reg              <= cur_next;
        k_reg                <= k_next;
        res_status_reg       <= res_status_next;
        res_ref_reg          <= res_ref_next;
        res_newp_reg         <= res_newp_next;
        status_reg           <= status_next;
        result_ref_reg       <= result_ref_next;
        new_caller_head_reg  <= new_caller_head_next;
        free_left_reg        <= free_left_next;
    end

    assign in_stall         = (state_reg != ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign result_ref       = result_ref_reg;
    assign new_caller_head  = new_caller_head_reg;
    assign free_left        = free_left_reg;

endmodule

`default_nettype wire

FILE: tb/gref_sb_pkg.sv
// scoreboard for the grant reference allocator: word type and free-list predictor
`timescale 1ns / 1ps

package gref_sb_pkg;

    import gref_pkg::*;

    localparam int ENTRIES  = 256;
    localparam int RESERVED = 8;
    localparam int RW       = 9;
    localparam int END_MARK = ENTRIES + 1;

    localparam logic [2:0] ACT_UNUSED = 3'd5;

    typedef struct packed {
        logic          status;
        logic [RW-1:0] result_ref;
        logic [RW-1:0] new_caller_head;
        logic [RW-1:0] free_left;
    } gref_word_t;

    class gref_scoreboard;

        logic [RW-1:0] links [ENTRIES];
        int unsigned   head_ref;
        int unsigned   free_cnt;
        gref_word_t    owed_replies[$];
        int            fails;

        function new();
            int i;
            for (i = 0; i < ENTRIES; i++)
                links[i] = (i >= RESERVED && i + 1 < ENTRIES) ? RW'(i + 1) : RW'(END_MARK);
            head_ref = RESERVED;
            free_cnt = ENTRIES - RESERVED;
            fails    = 0;
        endfunction

        function int unsigned link_at(int unsigned idx);
            if (idx < ENTRIES)
                return links[idx];
            return END_MARK;
        endfunction

        function void put_link(int unsigned idx, int unsigned val);
            if (idx < ENTRIES)
                links[idx] = RW'(val);
        endfunction

        function void grow_free(int unsigned n);
            free_cnt = (free_cnt + n > ENTRIES) ? ENTRIES : free_cnt + n;
        endfunction

        // predicts the reply to one accepted request word and queues it
        function gref_word_t take_request(logic [2:0] act, logic [RW-1:0] cnt,
                                          logic [RW-1:0] eref, logic [RW-1:0] phead);
            gref_word_t  w;
            int unsigned want;
            int unsigned walk;
            int unsigned nxt;
            int unsigned n;
            int unsigned steps;
            w.status           = STATUS_OK;
            w.result_ref       = RW'(END_MARK);
            w.new_caller_head  = phead;
            want = (cnt == 0) ? 1 : cnt;
            case (act)
                ACT_ALLOC:
                begin
                    if (free_cnt < want || head_ref >= ENTRIES)
                    begin
                        w.status = STATUS_NO_SPACE;
                    end
                    else
                    begin
                        w.result_ref = RW'(head_ref);
                        walk = head_ref;
                        free_cnt -= want;
                        n = 1;
                        while (n < want)
                        begin
                            nxt = link_at(walk);
                            if (nxt >= ENTRIES)
                                break;
                            walk = nxt;
                            n++;
                        end
                        head_ref = link_at(walk);
                        put_link(walk, END_MARK);
                    end
                end
                ACT_FREE_ONE:
                begin
                    if (eref < ENTRIES)
                    begin
                        put_link(eref, head_ref);
                        head_ref = eref;
                        grow_free(1);
                    end
                end
                ACT_FREE_CHAIN:
                begin
                    if (eref < ENTRIES)
                    begin
                        walk  = eref;
                        n     = 1;
                        steps = 0;
                        while (steps < ENTRIES)
                        begin
                            nxt = link_at(walk);
                            if (nxt >= ENTRIES)
                                break;
                            walk = nxt;
                            n++;
                            steps++;
                        end
                        put_link(walk, head_ref);
                        head_ref = eref;
                        grow_free(n);
                    end
                end
                ACT_CLAIM:
                begin
                    if (phead >= ENTRIES)
                    begin
                        w.status = STATUS_NO_SPACE;
                    end
                    else
                    begin
                        w.result_ref      = phead;
                        w.new_caller_head = RW'(link_at(phead));
                    end
                end
                ACT_RELEASE:
                begin
                    if (eref < ENTRIES)
                    begin
                        put_link(eref, phead);
                        w.new_caller_head = eref;
                    end
                end
                default:
                begin
                end
            endcase
            w.free_left = RW'(free_cnt);
            owed_replies.push_back(w);
            return w;
        endfunction

        function void check_reply(gref_word_t got);
            gref_word_t exp;
            if (owed_replies.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected word: %0d/%0d/%0d/%0d", got.status,
                             got.result_ref, got.new_caller_head, got.free_left);
                return;
            end
            exp = owed_replies.pop_front();
            if (got.status !== exp.status || got.result_ref !== exp.result_ref ||
                got.new_caller_head !== exp.new_caller_head || got.free_left !== exp.free_left)
            begin
                fails++;
                if (fails <= 10)
                    $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d %s",
                             exp.status, exp.result_ref, exp.new_caller_head, exp.free_left,
                             got.status, got.result_ref, got.new_caller_head, got.free_left,
                             "(status/result_ref/new_caller_head/free_left)");
            end
        endfunction

    endclass

endpackage

FILE: tb/grant_ref_free_list_allocator_core_tb.sv
// testbench top: drives random and directed allocator requests and checks every reply word
`timescale 1ns / 1ps

module grant_ref_free_list_allocator_core_tb;

    import gref_pkg::*;
    import gref_sb_pkg::*;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [2:0]    action = '0;
    logic [RW-1:0] count = '0;
    logic [RW-1:0] entry_ref = '0;
    logic [RW-1:0] caller_head = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic          status;
    logic [RW-1:0] result_ref;
    logic [RW-1:0] new_caller_head;
    logic [RW-1:0] free_left;

    bit             no_idle = 1'b0;
    gref_scoreboard sb = new();
    logic [RW-1:0]  held_singles[$];
    logic [RW-1:0]  held_chains[$];
    logic [RW-1:0]  priv = RW'(END_MARK);

    grant_ref_free_list_allocator_core #(
        .ENTRIES  (ENTRIES),
        .RESERVED (RESERVED)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .count            (count),
        .entry_ref        (entry_ref),
        .caller_head      (caller_head),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .result_ref       (result_ref),
        .new_caller_head  (new_caller_head),
        .free_left        (free_left)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_reply({status, result_ref, new_caller_head, free_left});
        out_stall <= !no_idle && ($urandom_range(0, 99) < 24);
    end

    task automatic send_word(input logic [2:0] act, input int unsigned cnt,
                             input int unsigned eref, input int unsigned phead,
                             output gref_word_t w);
        while (!no_idle && $urandom_range(0, 99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        count        <= RW'(cnt);
        entry_ref    <= RW'(eref);
        caller_head  <= RW'(phead);
        do
            @(posedge clk);
        while (in_stall);
        w = sb.take_request(act, RW'(cnt), RW'(eref), RW'(phead));
    endtask

    // at a full free count, takes the whole list and returns it so count and list agree
    task automatic resync_list();
        gref_word_t w;
        send_word(ACT_ALLOC, ENTRIES, 0, END_MARK, w);
        if (w.status == STATUS_OK)
            send_word(ACT_FREE_CHAIN, 0, w.result_ref, END_MARK, w);
    endtask

    task automatic take_entry(ref logic [RW-1:0] q[$], output logic [RW-1:0] e);
        int unsigned idx;
        idx = $urandom_range(0, q.size() - 1);
        e = q[idx];
        q.delete(idx);
    endtask

    task automatic random_item();
        gref_word_t    w;
        int unsigned   pick;
        int unsigned   cnt;
        logic [RW-1:0] e;
        if ($urandom_range(0, 99) < 15)
        begin
            send_word(3'($urandom_range(0, 7)), $urandom_range(0, 256), $urandom_range(0, 257),
                      $urandom_range(0, 257), w);
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 40 && held_singles.size() + held_chains.size() < 48)
        begin
            cnt = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 256) : $urandom_range(0, 6);
            send_word(ACT_ALLOC, cnt, $urandom_range(0, 257), $urandom_range(0, 257), w);
            if (w.status == STATUS_OK)
            begin
                if (cnt <= 1)
                    held_singles.push_back(w.result_ref);
                else
                    held_chains.push_back(w.result_ref);
            end
        end
        else if (pick < 55 && held_singles.size() != 0)
        begin
            take_entry(held_singles, e);
            send_word(ACT_FREE_ONE, $urandom_range(0, 256), e, $urandom_range(0, 257), w);
        end
        else if (pick < 70 && held_chains.size() != 0)
        begin
            take_entry(held_chains, e);
            send_word(ACT_FREE_CHAIN, $urandom_range(0, 256), e, $urandom_range(0, 257), w);
        end
        else if (pick < 85 && held_singles.size() != 0)
        begin
            take_entry(held_singles, e);
            send_word(ACT_RELEASE, $urandom_range(0, 256), e, priv, w);
            priv = w.new_caller_head;
        end
        else if (priv != END_MARK || $urandom_range(0, 9) == 0)
        begin
            send_word(ACT_CLAIM, $urandom_range(0, 256), $urandom_range(0, 257), priv, w);
            if (w.status == STATUS_OK)
                held_singles.push_back(w.result_ref);
            priv = w.new_caller_head;
        end
        else if (held_chains.size() != 0)
        begin
            take_entry(held_chains, e);
            send_word(ACT_FREE_CHAIN, 0, e, END_MARK, w);
        end
        else if (held_singles.size() != 0)
        begin
            take_entry(held_singles, e);
            send_word(ACT_FREE_ONE, 0, e, END_MARK, w);
        end
        else
        begin
            send_word(ACT_ALLOC, $urandom_range(0, 6), 0, END_MARK, w);
            if (w.status == STATUS_OK)
                held_chains.push_back(w.result_ref);
        end
    endtask

    initial
    begin
        gref_word_t    w;
        logic [RW-1:0] a;
        logic [RW-1:0] b;
        int            n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // basic alloc and free paths, plus refused and unknown requests
        send_word(ACT_ALLOC, 0, 0, END_MARK, w);
        a = w.result_ref;
        send_word(ACT_ALLOC, 3, 0, END_MARK, w);
        b = w.result_ref;
        send_word(ACT_FREE_ONE, 0, a, END_MARK, w);
        send_word(ACT_FREE_CHAIN, 0, b, END_MARK, w);
        send_word(ACT_FREE_CHAIN, 0, END_MARK, END_MARK, w);
        send_word(ACT_FREE_ONE, 0, ENTRIES, END_MARK, w);
        send_word(ACT_CLAIM, 0, 0, END_MARK, w);
        send_word(ACT_RELEASE, 0, ENTRIES, END_MARK, w);
        send_word(ACT_UNUSED, 256, 257, 257, w);

        // private chain round trip
        send_word(ACT_ALLOC, 1, 0, END_MARK, w);
        a = w.result_ref;
        send_word(ACT_RELEASE, 0, a, END_MARK, w);
        send_word(ACT_CLAIM, 0, 0, w.new_caller_head, w);
        send_word(ACT_FREE_ONE, 0, w.result_ref, END_MARK, w);
        send_word(ACT_ALLOC, ENTRIES, 0, END_MARK, w);

        // cut the free list short, then alloc past the cut
        send_word(ACT_RELEASE, 0, 100, END_MARK, w);
        send_word(ACT_ALLOC, 200, 0, END_MARK, w);
        b = w.result_ref;
        send_word(ACT_ALLOC, 1, 0, END_MARK, w);
        send_word(ACT_FREE_CHAIN, 0, 101, END_MARK, w);
        send_word(ACT_FREE_CHAIN, 0, b, END_MARK, w);
        resync_list();

        // self-looping chain handed to free chain
        send_word(ACT_RELEASE, 0, 1, 1, w);
        send_word(ACT_FREE_CHAIN, 0, 1, END_MARK, w);
        resync_list();

        for (n = 0; n < 1200; n++)
        begin
            no_idle = (n >= 500 && n < 700);
            random_item();
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        while (sb.owed_replies.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.fails == 0)
            $display("[grant_ref_free_list_allocator_core] OK");
        else
            $display("[grant_ref_free_list_allocator_core] ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[grant_ref_free_list_allocator_core] ERROR");
        $finish;
    end

endmodule
